// ===== rtl/izs_pkg.sv =====
// izs_pkg: shared types and constants of the irrigation zone sequencer
// item and result structs, configuration and state records, codes and reset values
// no dependencies
package izs_pkg;

    // event codes carried in the input item
    typedef enum logic [1:0] {
        OP_SOIL  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_opcode;

    // sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WATER = 2'd1,
        PH_ALERT = 2'd2,
        PH_REST  = 2'd3
    } t_phase;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_THR_ONE   = 3'd0,
        CFG_THR_TWO   = 3'd1,
        CFG_THR_THREE = 3'd2,
        CFG_HUM_LIMIT = 3'd3,
        CFG_WATER_SEC = 3'd4,
        CFG_MAX_CYC   = 3'd5,
        CFG_ALERT_SEC = 3'd6,
        CFG_REST_SEC  = 3'd7
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // configuration reset values
    localparam logic [11:0] THR_ONE_RST   = 12'd1000;
    localparam logic [11:0] THR_TWO_RST   = 12'd1500;
    localparam logic [11:0] THR_THREE_RST = 12'd2000;
    localparam logic [6:0]  HUM_LIMIT_RST = 7'd80;
    localparam logic [7:0]  WATER_SEC_RST = 8'd30;
    localparam logic [7:0]  MAX_CYC_RST   = 8'd30;
    localparam logic [3:0]  ALERT_SEC_RST = 4'd2;
    localparam logic [3:0]  REST_SEC_RST  = 4'd2;

    // servo pulse levels for 45, 90 and 135 degrees
    localparam logic [10:0] SERVO_LOW  = 11'd1000;
    localparam logic [10:0] SERVO_MID  = 11'd1500;
    localparam logic [10:0] SERVO_HIGH = 11'd2000;

    // dry masks that pick the narrower servo angles
    localparam logic [2:0] MASK_ONE   = 3'b001;
    localparam logic [2:0] MASK_TWO   = 3'b011;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] soil_level;
        logic [6:0]  humidity_percent;
        logic        intrusion;
    } t_in_item;

    typedef struct packed {
        logic        pump_on;
        logic        alert_on;
        logic [10:0] servo_pulse;
        logic [1:0]  active_zone;
        logic [7:0]  seconds_left;
        logic [2:0]  dry_mask;
        logic [7:0]  run_total;
        logic        maintenance_due;
        logic [1:0]  phase_now;
    } t_out_item;

    typedef struct packed {
        logic [11:0] thr_one;
        logic [11:0] thr_two;
        logic [11:0] thr_three;
        logic [6:0]  hum_limit;
        logic [7:0]  water_sec;
        logic [7:0]  run_limit;
        logic [3:0]  alert_sec;
        logic [3:0]  rest_sec;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  dry_bits;
        logic        start_pending;
        logic        abort_pending;
        t_phase      phase;
        logic [1:0]  zone_ptr;
        logic [7:0]  countdown;
        logic [3:0]  hold_cnt;
        logic [7:0]  run_cnt;
        logic [10:0] servo_level;
    } t_state;

    // next zone in cyclic order, pointer three folds to zero
    function automatic logic [1:0] next_zone(input logic [1:0] z);
        next_zone = (z >= 2'd2) ? 2'd0 : z + 2'd1;
    endfunction

endpackage

// ===== rtl/izs_step.sv =====
// izs_step: next-state and result logic for one event of the zone sequencer
// purely combinational, evaluated once per accepted item
// depends on izs_pkg
module izs_step
    import izs_pkg::*;
(
    input  t_cfg      i_cfg,
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    t_state     ns;
    logic       maint;
    logic [1:0] zp;
    logic [1:0] zsel;
    logic [2:0] mask;
    logic [7:0] cd;
    logic [3:0] hd;
    logic [7:0] runs;
    logic       do_start;
    logic       do_end;
    logic       intr_end;
    logic       do_finish;

    always_comb begin
        ns        = i_state;
        maint     = 1'b0;
        zp        = (i_state.zone_ptr == 2'd3) ? 2'd0 : i_state.zone_ptr;
        zsel      = zp;
        mask      = '0;
        cd        = '0;
        hd        = '0;
        runs      = '0;
        do_start  = 1'b0;
        do_end    = 1'b0;
        intr_end  = 1'b0;
        do_finish = 1'b0;

        case (t_opcode'(i_item.opcode))
            OP_SOIL: begin
                // dry mask from the three thresholds, high humidity clears it
                mask[0] = (i_item.soil_level < i_cfg.thr_one);
                mask[1] = (i_item.soil_level < i_cfg.thr_two);
                mask[2] = (i_item.soil_level < i_cfg.thr_three);
                if (i_item.humidity_percent > i_cfg.hum_limit) begin
                    mask = '0;
                end
                ns.dry_bits = mask;
            end
            OP_TICK: begin
                case (i_state.phase)
                    PH_IDLE: begin
                        ns.zone_ptr = zp;
                        // pending start wins, else cyclic search for a dry zone
                        if (i_state.start_pending) begin
                            do_start = 1'b1;
                            zsel     = zp;
                        end else begin
                            do_start = |i_state.dry_bits;
                            if (i_state.dry_bits[zp]) begin
                                zsel = zp;
                            end else if (i_state.dry_bits[next_zone(zp)]) begin
                                zsel = next_zone(zp);
                            end else begin
                                zsel = next_zone(next_zone(zp));
                            end
                        end
                    end
                    PH_WATER: begin
                        if (i_state.abort_pending) begin
                            do_end = 1'b1;
                        end else if (i_item.intrusion) begin
                            do_end   = 1'b1;
                            intr_end = 1'b1;
                        end else begin
                            cd = (i_state.countdown != '0) ? i_state.countdown - 8'd1 : '0;
                            ns.countdown = cd;
                            do_end = (cd == '0);
                        end
                    end
                    PH_ALERT: begin
                        hd = (i_state.hold_cnt != '0) ? i_state.hold_cnt - 4'd1 : '0;
                        ns.hold_cnt = hd;
                        do_finish = (hd == '0);
                    end
                    default: begin
                        hd = (i_state.hold_cnt != '0) ? i_state.hold_cnt - 4'd1 : '0;
                        ns.hold_cnt = hd;
                        if (hd == '0) begin
                            ns.phase = PH_IDLE;
                        end
                    end
                endcase

                // zone start
                if (do_start) begin
                    ns.zone_ptr      = zsel;
                    ns.start_pending = 1'b0;
                    ns.abort_pending = 1'b0;
                    if (i_state.dry_bits == MASK_ONE) begin
                        ns.servo_level = SERVO_LOW;
                    end else if (i_state.dry_bits == MASK_TWO) begin
                        ns.servo_level = SERVO_MID;
                    end else begin
                        ns.servo_level = SERVO_HIGH;
                    end
                    ns.phase     = PH_WATER;
                    ns.countdown = i_cfg.water_sec;
                    if (i_cfg.water_sec == '0) begin
                        do_end = 1'b1;
                    end
                end

                // zone end, intrusion goes to alert hold when it has length
                if (do_end) begin
                    ns.countdown = '0;
                    ns.zone_ptr  = next_zone(ns.zone_ptr);
                    if (intr_end && (i_cfg.alert_sec != '0)) begin
                        ns.phase    = PH_ALERT;
                        ns.hold_cnt = i_cfg.alert_sec;
                    end else begin
                        do_finish = 1'b1;
                    end
                end

                // run count, maintenance pulse and rest, or idle when the rest length is zero
                if (do_finish) begin
                    runs = i_state.run_cnt + 8'd1;
                    if (runs >= i_cfg.run_limit) begin
                        runs  = '0;
                        maint = 1'b1;
                    end
                    ns.run_cnt = runs;
                    if (i_cfg.rest_sec == '0) begin
                        ns.phase = PH_IDLE;
                    end else begin
                        ns.phase    = PH_REST;
                        ns.hold_cnt = i_cfg.rest_sec;
                    end
                end
            end
            OP_START: begin
                ns.start_pending = 1'b1;
            end
            default: begin
                ns.abort_pending = 1'b1;
            end
        endcase
    end

    // status result from the state after this event
    always_comb begin
        o_result.pump_on         = (ns.phase == PH_WATER);
        o_result.alert_on        = (ns.phase == PH_ALERT);
        o_result.servo_pulse     = ns.servo_level;
        o_result.active_zone     = (ns.phase == PH_WATER)
                                 ? ((ns.zone_ptr == 2'd3) ? 2'd1 : ns.zone_ptr + 2'd1)
                                 : 2'd0;
        o_result.seconds_left    = (ns.phase == PH_WATER) ? ns.countdown : 8'd0;
        o_result.dry_mask        = ns.dry_bits;
        o_result.run_total       = ns.run_cnt;
        o_result.maintenance_due = maint;
        o_result.phase_now       = ns.phase;
    end

    assign o_state = ns;

endmodule

// ===== rtl/irrigation_zone_sequencer.sv =====
// irrigation_zone_sequencer: top level with handshakes, configuration and state registers
// one result per accepted event; depends on izs_pkg and izs_step
// a result is valid in the cycle after its item transfer (one result register)
// throughput: one item per cycle while each result is taken; the state update and result are one combinational pass
// the input side stays ready while the result register is empty or being taken
// synchronous active-low reset: idle scan state, default configuration; config always ready
module irrigation_zone_sequencer
    import izs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      in_xfer;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // event evaluation
    izs_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_one    <= THR_ONE_RST;
            r_cfg.thr_two    <= THR_TWO_RST;
            r_cfg.thr_three  <= THR_THREE_RST;
            r_cfg.hum_limit  <= HUM_LIMIT_RST;
            r_cfg.water_sec  <= WATER_SEC_RST;
            r_cfg.run_limit  <= MAX_CYC_RST;
            r_cfg.alert_sec  <= ALERT_SEC_RST;
            r_cfg.rest_sec   <= REST_SEC_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_THR_ONE:   r_cfg.thr_one    <= i_cfg_data;
                CFG_THR_TWO:   r_cfg.thr_two    <= i_cfg_data;
                CFG_THR_THREE: r_cfg.thr_three  <= i_cfg_data;
                CFG_HUM_LIMIT: r_cfg.hum_limit  <= i_cfg_data[6:0];
                CFG_WATER_SEC: r_cfg.water_sec  <= i_cfg_data[7:0];
                CFG_MAX_CYC:   r_cfg.run_limit  <= i_cfg_data[7:0];
                CFG_ALERT_SEC: r_cfg.alert_sec  <= i_cfg_data[3:0];
                CFG_REST_SEC:  r_cfg.rest_sec   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.dry_bits      <= '0;
            r_state.start_pending <= 1'b0;
            r_state.abort_pending <= 1'b0;
            r_state.phase         <= PH_IDLE;
            r_state.zone_ptr      <= '0;
            r_state.countdown     <= '0;
            r_state.hold_cnt      <= '0;
            r_state.run_cnt       <= '0;
            r_state.servo_level   <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== test/tb_irrigation_zone_sequencer.sv =====
`timescale 1ns / 1ps
// tb_irrigation_zone_sequencer: self-checking testbench of the irrigation zone sequencer
// sends events with random gaps and register writes, predicts and checks every status transfer
// depends on izs_pkg and irrigation_zone_sequencer
module tb_irrigation_zone_sequencer;
    import izs_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_ROUNDS    = 6;
    localparam int EVENTS_PER_ROUND = 250;
    localparam int GAPLESS_EVENTS   = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted sequencer configuration and state
    t_cfg        model_cfg;
    logic [2:0]  dry_bits;
    logic        start_flag;
    logic        stop_flag;
    t_phase      phase;
    logic [1:0]  zone_ptr;
    logic [7:0]  countdown;
    logic [3:0]  hold_cnt;
    logic [7:0]  run_cnt;
    logic [10:0] servo_level;
    logic        maint_pulse;

    t_out_item status_fifo[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        gapless = 1'b0;

    irrigation_zone_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        if (gapless) begin
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // ---------------------------------------------------------------- predictor

    // count a finished run, then rest or go back to scanning
    function automatic void close_run();
        run_cnt = run_cnt + 8'd1;
        if (run_cnt >= model_cfg.run_limit) begin
            run_cnt     = '0;
            maint_pulse = 1'b1;
        end
        if (model_cfg.rest_sec == 4'd0) begin
            phase = PH_IDLE;
        end else begin
            phase    = PH_REST;
            hold_cnt = model_cfg.rest_sec;
        end
    endfunction

    // leave the watering phase and advance the zone pointer
    function automatic void end_watering(input bit intruded);
        countdown = '0;
        zone_ptr  = (zone_ptr >= 2'd2) ? 2'd0 : zone_ptr + 2'd1;
        if (intruded && model_cfg.alert_sec != 4'd0) begin
            phase    = PH_ALERT;
            hold_cnt = model_cfg.alert_sec;
        end else begin
            close_run();
        end
    endfunction

    // start watering a zone, servo level follows the dry mask
    function automatic void open_zone(input logic [1:0] zone);
        zone_ptr   = zone;
        start_flag = 1'b0;
        stop_flag  = 1'b0;
        if (dry_bits == MASK_ONE) begin
            servo_level = SERVO_LOW;
        end else if (dry_bits == MASK_TWO) begin
            servo_level = SERVO_MID;
        end else begin
            servo_level = SERVO_HIGH;
        end
        phase     = PH_WATER;
        countdown = model_cfg.water_sec;
        if (countdown == 8'd0) begin
            end_watering(1'b0);
        end
    endfunction

    // one-second tick in each phase
    function automatic void tick_sequencer(input logic intrusion);
        int         base;
        logic [1:0] zone;
        bit         found;
        found = 1'b0;
        case (phase)
            PH_IDLE: begin
                if (zone_ptr > 2'd2) begin
                    zone_ptr = 2'd0;
                end
                if (start_flag) begin
                    open_zone(zone_ptr);
                end else begin
                    base = int'(zone_ptr);
                    for (int k = 0; k < 3; k++) begin
                        zone = 2'((base + k) % 3);
                        if (!found && dry_bits[zone]) begin
                            found = 1'b1;
                            open_zone(zone);
                        end
                    end
                end
            end
            PH_WATER: begin
                if (stop_flag) begin
                    end_watering(1'b0);
                end else if (intrusion) begin
                    end_watering(1'b1);
                end else begin
                    if (countdown > 8'd0) countdown = countdown - 8'd1;
                    if (countdown == 8'd0) end_watering(1'b0);
                end
            end
            PH_ALERT: begin
                if (hold_cnt > 4'd0) hold_cnt = hold_cnt - 4'd1;
                if (hold_cnt == 4'd0) close_run();
            end
            default: begin
                if (hold_cnt > 4'd0) hold_cnt = hold_cnt - 4'd1;
                if (hold_cnt == 4'd0) phase = PH_IDLE;
            end
        endcase
    endfunction

    // apply one event and return the status it produces
    function automatic t_out_item predict_status(input t_in_item item);
        t_out_item  status;
        logic [2:0] mask;
        maint_pulse = 1'b0;
        case (t_opcode'(item.opcode))
            OP_SOIL: begin
                mask = {item.soil_level < model_cfg.thr_three,
                        item.soil_level < model_cfg.thr_two,
                        item.soil_level < model_cfg.thr_one};
                if (item.humidity_percent > model_cfg.hum_limit) begin
                    mask = 3'd0;
                end
                dry_bits = mask;
            end
            OP_TICK:  tick_sequencer(item.intrusion);
            OP_START: start_flag = 1'b1;
            default:  stop_flag = 1'b1;
        endcase
        status.pump_on         = (phase == PH_WATER);
        status.alert_on        = (phase == PH_ALERT);
        status.servo_pulse     = servo_level;
        status.active_zone     = (phase == PH_WATER) ? zone_ptr + 2'd1 : 2'd0;
        status.seconds_left    = (phase == PH_WATER) ? countdown : 8'd0;
        status.dry_mask        = dry_bits;
        status.run_total       = run_cnt;
        status.maintenance_due = maint_pulse;
        status.phase_now       = phase;
        return status;
    endfunction

    // ---------------------------------------------------------------- result side

    // ready drive with a random stall before each transfer
    initial begin : out_ready_drive
        int stall;
        out_ready = 1'b0;
        forever begin
            stall = pick_gap();
            @(negedge clk);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    function automatic void check_field(input string name, input logic [10:0] want,
                                        input logic [10:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // compare each status transfer with the oldest prediction
    always @(posedge clk) begin : status_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (status_fifo.size() == 0) begin
                mismatch_count++;
                $display("%0t: status expected none, actual %h", $time, out_data);
            end else begin
                want = status_fifo.pop_front();
                check_field("pump_on", 11'(want.pump_on), 11'(out_data.pump_on));
                check_field("alert_on", 11'(want.alert_on), 11'(out_data.alert_on));
                check_field("servo_pulse", want.servo_pulse, out_data.servo_pulse);
                check_field("active_zone", 11'(want.active_zone),
                            11'(out_data.active_zone));
                check_field("seconds_left", 11'(want.seconds_left),
                            11'(out_data.seconds_left));
                check_field("dry_mask", 11'(want.dry_mask), 11'(out_data.dry_mask));
                check_field("run_total", 11'(want.run_total), 11'(out_data.run_total));
                check_field("maintenance_due", 11'(want.maintenance_due),
                            11'(out_data.maintenance_due));
                check_field("phase_now", 11'(want.phase_now), 11'(out_data.phase_now));
            end
        end
    end

    // ---------------------------------------------------------------- event side

    // one event transfer, prediction made at the accepting edge
    task automatic send_event(input t_in_item item);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        status_fifo.push_back(predict_status(item));
    endtask

    task automatic send_op(input t_opcode op, input int unsigned soil,
                           input int unsigned humidity, input bit intrusion);
        t_in_item item;
        item.opcode           = op;
        item.soil_level       = soil[11:0];
        item.humidity_percent = humidity[6:0];
        item.intrusion        = intrusion;
        send_event(item);
    endtask

    // stop sending and wait until every status has come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (status_fifo.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[11:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_THR_ONE:   model_cfg.thr_one    = value[11:0];
            CFG_THR_TWO:   model_cfg.thr_two    = value[11:0];
            CFG_THR_THREE: model_cfg.thr_three  = value[11:0];
            CFG_HUM_LIMIT: model_cfg.hum_limit  = value[6:0];
            CFG_WATER_SEC: model_cfg.water_sec  = value[7:0];
            CFG_MAX_CYC:   model_cfg.run_limit  = value[7:0];
            CFG_ALERT_SEC: model_cfg.alert_sec  = value[3:0];
            default:       model_cfg.rest_sec   = value[3:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // full register set, written only once the block is idle
    task automatic apply_settings(input int unsigned thr1, input int unsigned thr2,
                                  input int unsigned thr3, input int unsigned hum,
                                  input int unsigned water, input int unsigned max_runs,
                                  input int unsigned alert, input int unsigned rest);
        settle();
        write_register(CFG_THR_ONE, thr1);
        write_register(CFG_THR_TWO, thr2);
        write_register(CFG_THR_THREE, thr3);
        write_register(CFG_HUM_LIMIT, hum);
        write_register(CFG_WATER_SEC, water);
        write_register(CFG_MAX_CYC, max_runs);
        write_register(CFG_ALERT_SEC, alert);
        write_register(CFG_REST_SEC, rest);
    endtask

    // ---------------------------------------------------------------- tests

    // threshold edges and humidity override at the default settings
    task automatic test_soil_thresholds();
        send_op(OP_TICK, 0, 0, 1'b0);
        send_op(OP_SOIL, 0, 0, 1'b0);
        send_op(OP_SOIL, 4095, 100, 1'b1);
        send_op(OP_SOIL, 999, 80, 1'b0);
        send_op(OP_SOIL, 1000, 80, 1'b0);
        send_op(OP_SOIL, 1500, 0, 1'b0);
        send_op(OP_SOIL, 2000, 0, 1'b0);
        send_op(OP_SOIL, 0, 81, 1'b0);
    endtask

    // countdown, rest, pending start and stop, intrusion alert, maintenance pulse
    task automatic test_zone_sequence();
        apply_settings(4095, 0, 0, 100, 2, 2, 1, 1);
        send_op(OP_SOIL, 10, 100, 1'b0);
        repeat (4) send_op(OP_TICK, 0, 0, 1'b0);
        send_op(OP_STOP, 0, 0, 1'b0);
        send_op(OP_START, 0, 0, 1'b0);
        send_op(OP_TICK, 0, 0, 1'b0);
        send_op(OP_TICK, 0, 0, 1'b1);
        send_op(OP_TICK, 0, 0, 1'b0);
        send_op(OP_TICK, 0, 0, 1'b0);
        send_op(OP_TICK, 0, 0, 1'b0);
        send_op(OP_STOP, 0, 0, 1'b0);
        send_op(OP_TICK, 0, 0, 1'b0);
    endtask

    // zero water, alert, rest and run limit, then intrusion without alert hold
    task automatic test_zero_lengths();
        apply_settings(100, 100, 0, 0, 0, 0, 0, 0);
        send_op(OP_SOIL, 0, 0, 1'b0);
        send_op(OP_TICK, 0, 0, 1'b0);
        send_op(OP_TICK, 0, 0, 1'b1);
        send_op(OP_SOIL, 0, 1, 1'b0);
        apply_settings(4095, 4095, 4095, 100, 1, 255, 0, 0);
        send_op(OP_SOIL, 4095, 0, 1'b0);
        send_op(OP_START, 0, 0, 1'b0);
        send_op(OP_TICK, 0, 0, 1'b0);
        send_op(OP_TICK, 0, 0, 1'b1);
        send_op(OP_SOIL, 4094, 0, 1'b0);
    endtask

    // mostly ticks, with soil readings near the thresholds and commands mixed in
    function automatic t_in_item random_event();
        t_in_item    item;
        int unsigned sel;
        int          edge_val;
        sel = $urandom_range(0, 99);
        item.soil_level       = 12'($urandom_range(0, 4095));
        item.humidity_percent = 7'($urandom_range(0, 100));
        item.intrusion        = ($urandom_range(0, 9) == 0);
        if (sel < 55) begin
            item.opcode = OP_TICK;
        end else if (sel < 78) begin
            item.opcode = OP_SOIL;
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 2))
                    0:       edge_val = int'(model_cfg.thr_one);
                    1:       edge_val = int'(model_cfg.thr_two);
                    default: edge_val = int'(model_cfg.thr_three);
                endcase
                edge_val = edge_val + $urandom_range(0, 2) - 1;
                if (edge_val < 0) edge_val = 0;
                if (edge_val > 4095) edge_val = 4095;
                item.soil_level = 12'(edge_val);
            end
            if ($urandom_range(0, 3) != 0) begin
                item.humidity_percent = 7'($urandom_range(0, model_cfg.hum_limit));
            end
        end else if (sel < 89) begin
            item.opcode = OP_START;
        end else begin
            item.opcode = OP_STOP;
        end
        return item;
    endfunction

    // rounds of random traffic, low and high register extremes first
    task automatic test_random_traffic();
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            if (round == 0) begin
                apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), 0, 1, 1, 0, 0);
            end else if (round == 1) begin
                apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), 100, 255, 255, 15, 15);
            end else begin
                apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), $urandom_range(40, 100),
                               $urandom_range(1, 12), $urandom_range(1, 6),
                               $urandom_range(0, 4), $urandom_range(0, 4));
            end
            for (int n = 0; n < EVENTS_PER_ROUND; n++) begin
                gapless = (n < GAPLESS_EVENTS);
                send_event(random_event());
            end
            gapless = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- main sequence
    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        model_cfg = '{thr_one: THR_ONE_RST, thr_two: THR_TWO_RST, thr_three: THR_THREE_RST,
                      hum_limit: HUM_LIMIT_RST, water_sec: WATER_SEC_RST,
                      run_limit: MAX_CYC_RST, alert_sec: ALERT_SEC_RST,
                      rest_sec: REST_SEC_RST};
        dry_bits    = '0;
        start_flag  = 1'b0;
        stop_flag   = 1'b0;
        phase       = PH_IDLE;
        zone_ptr    = '0;
        countdown   = '0;
        hold_cnt    = '0;
        run_cnt     = '0;
        servo_level = '0;
        maint_pulse = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_soil_thresholds();
        test_zone_sequence();
        test_zero_lengths();
        test_random_traffic();
        settle();

        if (mismatch_count == 0 && status_fifo.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
